@@ rtl/buddy_tree_bitmap_marker_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the buddy tree bitmap marker unit.
// Define NO_ASSERTIONS to compile every check away.
// ----------------------------------------------------------------------------
`ifndef BUDDY_TREE_BITMAP_MARKER_UNIT_MACROS_SVH
`define BUDDY_TREE_BITMAP_MARKER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked at every rising edge out of reset.
`define BTBM_ASSERT_IMPL(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("btbm: same-cycle check failed");

// Next-cycle implication.
`define BTBM_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("btbm: next-cycle check failed");

`else

`define BTBM_ASSERT_IMPL(name, clk, rstn, ante, cons)
`define BTBM_ASSERT_NEXT(name, clk, rstn, ante, cons)

`endif

`endif

@@ rtl/btbm_pkg.sv @@
// ----------------------------------------------------------------------------
// btbm_pkg
// Shared types and constants of the buddy tree bitmap marker unit.
// ----------------------------------------------------------------------------
`default_nettype none

package btbm_pkg;

    localparam int NODE_W   = 8;                    // node_index width
    localparam int USED_W   = 9;                    // used_bits width
    localparam int BYTE_W   = 8;                    // bits per memory row
    localparam int LANE_W   = 3;                    // bit select within a row
    localparam int POS_W    = 11;                   // walk position, holds first + width
    localparam int ROWPTR_W = POS_W - LANE_W;
    localparam int MAX_BOUND = (1 << USED_W) - 1;   // largest bound used_bits can give

    localparam logic [USED_W-1:0] USED_RESET = USED_W'(256);

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_MARK  = 2'd2,
        CMD_PROP  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_MODIFY,
        ST_DONE
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture the accepted item
        logic rd_en;      // issue a row read
        logic modify;     // row data is back: write it and step the walk
        logic out_load;   // move the finished result into the output register
    } ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic reject_in;  // item at the input port would be refused
        logic walk_done;  // the current row is the last one of the command
        logic out_busy;   // output register full and not taken this cycle
    } status_t;

endpackage

`default_nettype wire

@@ rtl/btbm_ram.sv @@
// ----------------------------------------------------------------------------
// btbm_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module btbm_ram #(
    parameter  int WIDTH  = 8,
    parameter  int DEPTH  = 32,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ rtl/btbm_ctrl.sv @@
// ----------------------------------------------------------------------------
// btbm_ctrl
// Sequencer: accept an item, run read-modify-write row steps, hand off result.
// ----------------------------------------------------------------------------
`default_nettype none

module btbm_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire btbm_pkg::status_t status,
    output btbm_pkg::ctl_t        ctl
);

    btbm_pkg::state_t state_reg;
    btbm_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= btbm_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        ctl        = '0;
        case (state_reg)
            btbm_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    ctl.load   = 1'b1;
                    state_next = status.reject_in ? btbm_pkg::ST_DONE : btbm_pkg::ST_READ;
                end
            end
            btbm_pkg::ST_READ: begin
                ctl.rd_en  = 1'b1;
                state_next = btbm_pkg::ST_MODIFY;
            end
            btbm_pkg::ST_MODIFY: begin
                ctl.modify = 1'b1;
                state_next = status.walk_done ? btbm_pkg::ST_DONE : btbm_pkg::ST_READ;
            end
            btbm_pkg::ST_DONE: begin
                if (!status.out_busy) begin
                    ctl.out_load = 1'b1;
                    state_next   = btbm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = btbm_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/btbm_datapath.sv @@
// ----------------------------------------------------------------------------
// btbm_datapath
// Bitmap row memory, walk registers, row mask logic and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module btbm_datapath #(
    parameter int NODE_COUNT = 256
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire btbm_pkg::ctl_t                   ctl,
    output btbm_pkg::status_t                     status,
    input  wire logic [1:0]                       s_cmd,
    input  wire logic [btbm_pkg::NODE_W-1:0]      s_node_index,
    input  wire logic                             s_value_bit,
    input  wire logic                             cfg_wr_en,
    input  wire logic [btbm_pkg::USED_W-1:0]      cfg_wr_data,
    input  wire logic                             m_ready,
    output logic                                  m_valid,
    output logic                                  m_bit_value,
    output logic                                  m_rejected
);

    // Only nodes below the bound are ever written, and the bound never
    // exceeds what used_bits can express, so storage stops there.
    localparam int CAP         = (NODE_COUNT < btbm_pkg::MAX_BOUND) ?
                                 NODE_COUNT : btbm_pkg::MAX_BOUND;
    localparam int STORE_NODES = (NODE_COUNT < btbm_pkg::MAX_BOUND + 1) ?
                                 NODE_COUNT : btbm_pkg::MAX_BOUND + 1;
    localparam int ROWS        = (STORE_NODES + btbm_pkg::BYTE_W - 1) / btbm_pkg::BYTE_W;
    localparam int ROW_W       = (ROWS > 1) ? $clog2(ROWS) : 1;

    localparam logic [btbm_pkg::USED_W-1:0] CAP_BOUND = btbm_pkg::USED_W'(CAP);
    localparam int PW = btbm_pkg::POS_W;
    localparam int LW = btbm_pkg::LANE_W;
    localparam int BW = btbm_pkg::BYTE_W;

    // configuration and control state
    logic [btbm_pkg::USED_W-1:0] used_bits_reg;
    logic [ROWS-1:0]             row_vld_reg;
    logic                        m_valid_reg;

    // per-item payload
    btbm_pkg::cmd_t              cmd_reg;
    logic                        val_reg;
    logic                        rdtype_reg;
    logic [btbm_pkg::USED_W-1:0] lim_reg;
    logic [PW-1:0]               pos_reg;
    logic [PW-1:0]               span_reg;
    logic [btbm_pkg::ROWPTR_W-1:0] row_reg;
    logic                        row_vld_q_reg;
    logic                        res_bit_reg;
    logic                        res_rej_reg;
    logic                        m_bit_reg;
    logic                        m_rej_reg;

    logic [btbm_pkg::USED_W-1:0] bound;
    logic                        reject_in;
    btbm_pkg::cmd_t              cmd_in;
    logic [ROW_W-1:0]            row_addr;
    logic [BW-1:0]               ram_q;
    logic [BW-1:0]               old_byte;
    logic [BW-1:0]               bit_mask;
    logic [BW-1:0]               mark_mask;
    logic [BW-1:0]               mask;
    logic [BW-1:0]               new_byte;
    logic                        wr_en;
    logic [PW-1:0]               lim_ext;
    logic [PW-1:0]               end_full;
    logic [PW-1:0]               mark_end;
    logic [PW-1:0]               end_m1;
    logic                        mark_last;
    logic [PW-1:0]               next_first;
    logic [PW-1:0]               prop_next;
    logic                        buddy_set;
    logic                        walk_done;

    assign cmd_in    = btbm_pkg::cmd_t'(s_cmd);
    assign bound     = (used_bits_reg < CAP_BOUND) ? used_bits_reg : CAP_BOUND;
    assign reject_in = (s_node_index == '0) ||
                       ({1'b0, s_node_index} >= bound);

    assign row_addr = row_reg[ROW_W-1:0];
    assign old_byte = row_vld_q_reg ? ram_q : '0;   // never-written row reads as free

    // level range of a subtree mark: [pos, min(pos + span, lim))
    assign lim_ext    = PW'(lim_reg);
    assign end_full   = pos_reg + span_reg;
    assign mark_end   = (end_full < lim_ext) ? end_full : lim_ext;
    assign end_m1     = mark_end - PW'(1);
    assign mark_last  = (row_reg == end_m1[PW-1:LW]);
    assign next_first = pos_reg << 1;
    assign prop_next  = pos_reg >> 1;
    assign buddy_set  = old_byte[pos_reg[LW-1:0] ^ LW'(1)];

    always_comb begin
        logic [PW-1:0] p;
        p = '0;
        for (int b = 0; b < BW; b++) begin
            p            = {row_reg, LW'(b)};
            mark_mask[b] = (p >= pos_reg) && (p < mark_end);
        end
    end

    assign bit_mask = BW'(1) << pos_reg[LW-1:0];
    assign mask     = (cmd_reg == btbm_pkg::CMD_MARK) ? mark_mask : bit_mask;
    assign new_byte = val_reg ? (old_byte | mask) : (old_byte & ~mask);
    assign wr_en    = ctl.modify && !rdtype_reg;

    always_comb begin
        walk_done = 1'b1;
        if (!rdtype_reg) begin
            case (cmd_reg)
                btbm_pkg::CMD_WRITE: walk_done = 1'b1;
                btbm_pkg::CMD_READ:  walk_done = 1'b1;
                btbm_pkg::CMD_MARK:  walk_done = mark_last && (next_first >= lim_ext);
                btbm_pkg::CMD_PROP:  begin
                    // stop below the root; clearing also stops at a used buddy
                    walk_done = (prop_next[PW-1:1] == '0) || (!val_reg && buddy_set);
                end
                default:             walk_done = 1'b1;
            endcase
        end
    end

    assign status.reject_in = reject_in;
    assign status.walk_done = walk_done;
    assign status.out_busy  = m_valid_reg && !m_ready;

    btbm_ram #(
        .WIDTH (BW),
        .DEPTH (ROWS)
    ) u_rows (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (row_addr),
        .wr_data (new_byte),
        .rd_en   (ctl.rd_en),
        .rd_addr (row_addr),
        .rd_data (ram_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_bits_reg <= btbm_pkg::USED_RESET;
            row_vld_reg   <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                used_bits_reg <= cfg_wr_data;
            end
            if (wr_en) begin
                row_vld_reg[row_addr] <= 1'b1;
            end
            if (ctl.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            cmd_reg     <= cmd_in;
            val_reg     <= s_value_bit;
            rdtype_reg  <= (cmd_in == btbm_pkg::CMD_READ) ||
                           ((cmd_in == btbm_pkg::CMD_PROP) &&
                            (s_node_index == btbm_pkg::NODE_W'(1)));
            lim_reg     <= bound;
            pos_reg     <= PW'(s_node_index);
            span_reg    <= PW'(1);
            row_reg     <= btbm_pkg::ROWPTR_W'(s_node_index >> LW);
            res_bit_reg <= 1'b0;
            res_rej_reg <= reject_in;
        end
        if (ctl.rd_en) begin
            row_vld_q_reg <= row_vld_reg[row_addr];
        end
        if (ctl.modify) begin
            if (walk_done) begin
                res_bit_reg <= rdtype_reg ? old_byte[pos_reg[LW-1:0]] : val_reg;
            end else if (cmd_reg == btbm_pkg::CMD_MARK) begin
                if (mark_last) begin
                    pos_reg  <= next_first;
                    span_reg <= span_reg << 1;
                    row_reg  <= next_first[PW-1:LW];
                end else begin
                    row_reg  <= row_reg + btbm_pkg::ROWPTR_W'(1);
                end
            end else begin
                pos_reg <= prop_next;
                row_reg <= prop_next[PW-1:LW];
            end
        end
        if (ctl.out_load) begin
            m_bit_reg <= res_bit_reg;
            m_rej_reg <= res_rej_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_bit_value = m_bit_reg;
    assign m_rejected  = m_rej_reg;

endmodule

`default_nettype wire

@@ rtl/buddy_tree_bitmap_marker_unit.sv @@
// ----------------------------------------------------------------------------
// buddy_tree_bitmap_marker_unit
// Bitmap keeper for a 1-indexed binary buddy tree: write, read, subtree mark
// and upward propagation, one command at a time.
//
// Usage: commands enter on the s_ valid/ready channel, one result per command
// leaves on the m_ valid/ready channel. used_bits is written through
// cfg_wr_en/cfg_wr_data while the unit is idle.
// Each command runs R read-modify-write steps on a byte-wide row memory: a row
// read, then a write-back that read and root propagation skip. The unit is
// ready for the next command in the same cycle that m_valid rises. R is 1 for
// read, write and propagation at the root; refused commands use no step;
// propagation uses one step per tree level climbed (up to 7 at 256 nodes);
// a subtree mark uses one step per memory row per level (up to 34 at 256 nodes).
// The one-row-at-a-time memory access and that step loop set the rate.
// A finished result waits in the output register while the receiver stalls;
// the next command is taken meanwhile and holds in its last cycle until the
// register frees.
// Reset: used_bits returns to 256 and every node reads free at once through
// per-row valid flags, with no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

`include "buddy_tree_bitmap_marker_unit_macros.svh"

module buddy_tree_bitmap_marker_unit #(
    parameter int NODE_COUNT = 256
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [1:0]                  s_cmd,
    input  wire logic [btbm_pkg::NODE_W-1:0] s_node_index,
    input  wire logic                        s_value_bit,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic                             m_bit_value,
    output logic                             m_rejected,
    input  wire logic                        cfg_wr_en,
    input  wire logic [btbm_pkg::USED_W-1:0] cfg_wr_data
);

    btbm_pkg::ctl_t    ctl;
    btbm_pkg::status_t status;

    btbm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .ctl     (ctl)
    );

    btbm_datapath #(
        .NODE_COUNT (NODE_COUNT)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctl          (ctl),
        .status       (status),
        .s_cmd        (s_cmd),
        .s_node_index (s_node_index),
        .s_value_bit  (s_value_bit),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_bit_value  (m_bit_value),
        .m_rejected   (m_rejected)
    );

    // one command in flight: no second transfer right behind the first
    `BTBM_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_valid && s_ready, !s_ready)
    // a refused command never reports a set bit
    `BTBM_ASSERT_IMPL(a_reject_bit_zero, aclk, aresetn, m_valid && m_rejected, !m_bit_value)
    // a result is never loaded over one the receiver has not taken
    `BTBM_ASSERT_IMPL(a_no_overwrite, aclk, aresetn, ctl.out_load, !m_valid || m_ready)

endmodule

`default_nettype wire
